FILE: sv/svsa_pkg.sv
// Shared types and constants for the voice slot allocator.
// No dependencies; imported by every module of the block.
package svsa_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam logic [7:0] FREE_CODE_DEF = 8'hFF;
  localparam int CHAN_COUNT = 256;

  localparam logic [15:0] PRIO_NONE = 16'hFFFF;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;
  localparam logic [5:0] RESULT_NONE = 6'h3F;
  localparam logic [5:0] SLOTS_IN_USE_RST = 6'd32;

  typedef enum logic [1:0] {
    REQ_WRITE_SLOT    = 2'd0,
    REQ_WRITE_COUNTER = 2'd1,
    REQ_SELECT        = 2'd2,
    REQ_FIND          = 2'd3
  } req_t;

  typedef struct packed {
    logic [7:0]  owner;
    logic        active;
    logic [7:0]  variant;
    logic [15:0] prio;
  } slot_entry_t;

  // scan unit control from the sequencer
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // candidates gathered over one scan
  typedef struct packed {
    logic        have_free;
    logic [5:0]  free_idx;
    logic        have_inact;
    logic [5:0]  inact_idx;
    logic [7:0]  inact_owner;
    logic        have_match;
    logic [5:0]  match_idx;
    logic [15:0] min_prio;
    logic [5:0]  min_idx;
    logic [7:0]  min_owner;
    logic        have_find;
    logic [5:0]  find_idx;
  } scan_res_t;

endpackage

FILE: sv/svsa_slot_table.sv
// Voice slot table: one write port, one registered read port.
// Per-slot valid bits make unwritten slots read as free. Uses svsa_pkg.
module svsa_slot_table import svsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int SLOT_AW = 5,
  parameter logic [7:0] FREE_CODE = FREE_CODE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [SLOT_AW-1:0] waddr,
  input  slot_entry_t        wentry,
  input  logic [SLOT_AW-1:0] raddr,
  output slot_entry_t        rentry
);

  slot_entry_t mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld;
  slot_entry_t rd_q;
  logic rd_vld_q;
  slot_entry_t rst_entry;

  assign rst_entry = '{owner: FREE_CODE, active: 1'b0, variant: 8'd0, prio: PRIO_NONE};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wentry;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld_q <= vld[raddr];
    end
  end

  assign rentry = rd_vld_q ? rd_q : rst_entry;

endmodule

FILE: sv/svsa_ctr_table.sv
// Per-channel counter table, 256 entries, registered read.
// Valid bits make unwritten counters read as zero. Uses svsa_pkg.
module svsa_ctr_table import svsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [CHAN_COUNT];
  logic [CHAN_COUNT-1:0] vld;
  logic [7:0] rd_q;
  logic rd_vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld_q <= vld[raddr];
    end
  end

  assign rdata = rd_vld_q ? rd_q : 8'd0;

endmodule

FILE: sv/svsa_scan_unit.sv
// Shared compare unit: looks at one slot per step and keeps the
// select and find candidates. Uses svsa_pkg.
module svsa_scan_unit import svsa_pkg::*; #(
  parameter int SLOT_AW = 5,
  parameter logic [7:0] FREE_CODE = FREE_CODE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  scan_ctl_t          ctl,
  input  logic [SLOT_AW-1:0] idx,
  input  slot_entry_t        entry,
  input  logic [7:0]         who,
  input  logic [7:0]         var_tag,
  output scan_res_t          res
);

  logic [15:0] find_prio;
  logic [5:0] idx6;

  assign idx6 = 6'(idx);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      res.have_free <= 1'b0;
      res.have_inact <= 1'b0;
      res.have_match <= 1'b0;
      res.have_find <= 1'b0;
      res.min_prio <= PRIO_NONE;
      find_prio <= PRIO_NONE;
    end else if (ctl.step) begin
      if (!res.have_free && entry.owner == FREE_CODE) begin
        res.have_free <= 1'b1;
        res.free_idx <= idx6;
      end
      if (!res.have_inact && !entry.active) begin
        res.have_inact <= 1'b1;
        res.inact_idx <= idx6;
        res.inact_owner <= entry.owner;
      end
      if (!res.have_match && entry.owner == who && entry.variant == var_tag) begin
        res.have_match <= 1'b1;
        res.match_idx <= idx6;
      end
      // strict: the earliest lowest priority wins
      if (entry.prio < res.min_prio) begin
        res.min_prio <= entry.prio;
        res.min_idx <= idx6;
        res.min_owner <= entry.owner;
      end
      // non-strict: the latest active lowest priority wins
      if (entry.prio <= find_prio && entry.owner == who && entry.active) begin
        find_prio <= entry.prio;
        res.find_idx <= idx6;
        res.have_find <= 1'b1;
      end
    end
  end

endmodule

FILE: sv/sound_voice_slot_allocator_core.sv
// Voice slot allocator with stealing. A select or find scans the first
// min(slots_in_use, SLOT_COUNT) slots one per cycle through the slot table's
// single read port, and when a select takes a slot with an owner, that owner's
// counter goes through its read-modify-write. One word is in work at a time:
// s_axis_tready is high only while the sequencer is idle.
module sound_voice_slot_allocator_core import svsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter logic [7:0] FREE_CODE = FREE_CODE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,      // slots_in_use
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] slot, [12:5] owner, [20:13] variant, [21] active,
  // [37:22] priority_req, [45:38] counter
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] slot_result, [13:6] owner_touched, [21:14] counter_after
  output logic [23:0] m_axis_tdata
);

  localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [6:0] SLOT_COUNT_7 = 7'(SLOT_COUNT);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_CRD    = 6'b001000,
    ST_CMOD   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state;
  logic [5:0] slots_in_use;

  // input fields
  req_t in_req;
  logic [4:0] in_slot;
  logic [7:0] in_owner, in_variant, in_counter;
  slot_entry_t in_entry;
  logic accept;

  assign in_req = req_t'(s_axis_tuser);
  assign in_slot = s_axis_tdata[4:0];
  assign in_owner = s_axis_tdata[12:5];
  assign in_variant = s_axis_tdata[20:13];
  assign in_counter = s_axis_tdata[45:38];
  assign in_entry = '{owner: s_axis_tdata[12:5], active: s_axis_tdata[21],
                      variant: s_axis_tdata[20:13], prio: s_axis_tdata[37:22]};
  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // request context
  req_t req_q;
  logic [7:0] who_q, var_q;

  // scan control
  logic [CNT_W-1:0] scan_idx, n_eff;
  logic [6:0] n7, slot7;
  logic issue, step_q;
  logic [SLOT_AW-1:0] idx_q;
  scan_ctl_t scan_ctl;
  scan_res_t scan_res;
  slot_entry_t rentry;

  assign n7 = ({1'b0, slots_in_use} > SLOT_COUNT_7) ? SLOT_COUNT_7 : {1'b0, slots_in_use};
  assign n_eff = n7[CNT_W-1:0];
  assign issue = (state == ST_SCAN) && (scan_idx < n_eff);
  assign scan_ctl = '{clear: accept, step: step_q};
  assign slot7 = {2'b00, in_slot};

  // slot table
  logic slot_we;
  assign slot_we = accept && in_req == REQ_WRITE_SLOT && slot7 < SLOT_COUNT_7;

  svsa_slot_table #(
    .SLOT_COUNT(SLOT_COUNT), .SLOT_AW(SLOT_AW), .FREE_CODE(FREE_CODE)
  ) u_slots (
    .clk(clk), .rst(rst),
    .we(slot_we), .waddr(slot7[SLOT_AW-1:0]), .wentry(in_entry),
    .raddr(scan_idx[SLOT_AW-1:0]), .rentry(rentry)
  );

  svsa_scan_unit #(.SLOT_AW(SLOT_AW), .FREE_CODE(FREE_CODE)) u_scan (
    .clk(clk), .rst(rst), .ctl(scan_ctl), .idx(idx_q), .entry(rentry),
    .who(who_q), .var_tag(var_q), .res(scan_res)
  );

  // counter table
  logic [7:0] take_owner, ctr_rdata, ctr_new, ctr_waddr, ctr_wdata;
  logic ctr_we;

  assign ctr_new = ((ctr_rdata[3:0] & NIBBLE_MASK) != 4'd0) ? ctr_rdata - 8'd1 : ctr_rdata;

  always_comb begin
    ctr_we = 1'b0;
    ctr_waddr = take_owner;
    ctr_wdata = ctr_new;
    if (accept && in_req == REQ_WRITE_COUNTER) begin
      ctr_we = 1'b1;
      ctr_waddr = in_owner;
      ctr_wdata = in_counter;
    end else if (state == ST_CMOD) begin
      ctr_we = 1'b1;
    end
  end

  svsa_ctr_table u_ctr (
    .clk(clk), .rst(rst), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
    .raddr(take_owner), .rdata(ctr_rdata)
  );

  // result
  logic [5:0] res_slot;
  logic [7:0] res_owner, res_count;
  logic out_valid;
  logic [5:0] out_slot;
  logic [7:0] out_owner, out_count;
  logic out_load;

  assign out_load = (state == ST_DONE) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {2'b00, out_count, out_owner, out_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RST;
    end else if (cfg_we) begin
      slots_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step_q <= 1'b0;
      out_valid <= 1'b0;
      scan_idx <= '0;
    end else begin
      step_q <= issue;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            scan_idx <= '0;
            if (in_req == REQ_SELECT || in_req == REQ_FIND) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_idx <= CNT_W'(scan_idx + 1'b1);
          end else if (!step_q) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state <= ST_DONE;
          if (req_q == REQ_SELECT && !scan_res.have_free) begin
            if (scan_res.have_inact && scan_res.inact_owner != FREE_CODE) begin
              state <= ST_CRD;
            end else if (!scan_res.have_inact && scan_res.have_match &&
                         who_q != FREE_CODE) begin
              state <= ST_CRD;
            end else if (!scan_res.have_inact && !scan_res.have_match &&
                         scan_res.min_prio != PRIO_NONE &&
                         scan_res.min_owner != FREE_CODE) begin
              state <= ST_CRD;
            end
          end
        end
        ST_CRD: begin
          state <= ST_CMOD;
        end
        ST_CMOD: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_q <= scan_idx[SLOT_AW-1:0];
    if (accept) begin
      req_q <= in_req;
      who_q <= in_owner;
      var_q <= in_variant;
      res_slot <= 6'd0;
      res_owner <= FREE_CODE;
      res_count <= 8'd0;
    end
    if (state == ST_DECIDE) begin
      if (req_q == REQ_FIND) begin
        res_slot <= scan_res.have_find ? scan_res.find_idx : RESULT_NONE;
      end else if (scan_res.have_free) begin
        res_slot <= scan_res.free_idx;
      end else if (scan_res.have_inact) begin
        res_slot <= scan_res.inact_idx;
        take_owner <= scan_res.inact_owner;
      end else if (scan_res.have_match) begin
        res_slot <= scan_res.match_idx;
        take_owner <= who_q;
      end else if (scan_res.min_prio != PRIO_NONE) begin
        res_slot <= scan_res.min_idx;
        take_owner <= scan_res.min_owner;
      end else begin
        res_slot <= RESULT_NONE;
      end
    end
    if (state == ST_CMOD) begin
      res_owner <= take_owner;
      res_count <= ctr_new;
    end
    if (out_load) begin
      out_slot <= res_slot;
      out_owner <= res_owner;
      out_count <= res_count;
    end
  end

endmodule

FILE: sv/svsa_checker.sv
// Port-level checks for the voice slot allocator, bound to the top level.
// Uses svsa_pkg; sees only the ports of sound_voice_slot_allocator_core.
module svsa_checker import svsa_pkg::*; #(
  parameter logic [7:0] FREE_CODE = FREE_CODE_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // every word keeps the block busy: ready is low in the cycle after an accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready high right after an accepted word");

  // no counter examined means counter_after reads zero
  a_untouched_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[13:6] == FREE_CODE |-> m_axis_tdata[21:14] == 8'd0)
    else $error("counter_after nonzero with no owner touched");

  // no new result appears in the cycle after ready was high with no word offered and no result pending
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    $past(s_axis_tready) && !$past(s_axis_tvalid) && !$past(m_axis_tvalid)
    |-> !m_axis_tvalid)
    else $error("result produced without an accepted word");

endmodule

bind sound_voice_slot_allocator_core svsa_checker #(.FREE_CODE(FREE_CODE)) u_svsa_checker (.*);

FILE: test/voice_alloc_checker.sv
`timescale 1ns / 100ps
// Result checker for sound_voice_slot_allocator_core: tracks the slot and
// channel counter tables from the accepted request words and compares each
// result word with its prediction. Depends on svsa_pkg.
module voice_alloc_checker import svsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0] counter_after;
    logic [7:0] owner_touched;
    logic [5:0] slot_result;
  } alloc_word_t;

  slot_entry_t voices [SLOT_COUNT_DEF];
  logic [7:0]  chan_count [CHAN_COUNT];
  logic [5:0]  scan_limit;
  alloc_word_t pending_allocs [$];
  int          errors;
  int          word_no;

  function automatic int scan_count();
    return (scan_limit > SLOT_COUNT_DEF) ? SLOT_COUNT_DEF : int'(scan_limit);
  endfunction

  // steal: the owner's counter drops by one unless its low nibble is zero
  function automatic alloc_word_t take_voice(input int idx);
    alloc_word_t w;
    logic [7:0]  own;
    own = voices[idx].owner;
    w = '{counter_after: 8'h00, owner_touched: FREE_CODE_DEF, slot_result: 6'(idx)};
    if (own != FREE_CODE_DEF) begin
      if ((chan_count[own] & {4'h0, NIBBLE_MASK}) != 8'h00)
        chan_count[own] = chan_count[own] - 8'd1;
      w.owner_touched = own;
      w.counter_after = chan_count[own];
    end
    return w;
  endfunction

  function automatic alloc_word_t pick_voice(input logic [7:0] who, input logic [7:0] var_tag);
    alloc_word_t w;
    int          n;
    int          pick;
    logic [15:0] best;
    n = scan_count();
    w = '{counter_after: 8'h00, owner_touched: FREE_CODE_DEF, slot_result: RESULT_NONE};
    for (int i = 0; i < n; i++)
      if (voices[i].owner == FREE_CODE_DEF) begin
        w.slot_result = 6'(i);
        return w;
      end
    for (int i = 0; i < n; i++)
      if (!voices[i].active) return take_voice(i);
    for (int i = 0; i < n; i++)
      if (voices[i].owner == who && voices[i].variant == var_tag) return take_voice(i);
    best = PRIO_NONE;
    pick = 0;
    for (int i = 0; i < n; i++)
      if (voices[i].prio < best) begin
        best = voices[i].prio;
        pick = i;
      end
    if (best == PRIO_NONE) return w;
    return take_voice(pick);
  endfunction

  // later slot wins a priority tie
  function automatic alloc_word_t find_voice(input logic [7:0] who);
    alloc_word_t w;
    int          n;
    logic [15:0] best;
    n = scan_count();
    best = PRIO_NONE;
    w = '{counter_after: 8'h00, owner_touched: FREE_CODE_DEF, slot_result: RESULT_NONE};
    for (int i = 0; i < n; i++)
      if (best >= voices[i].prio && voices[i].owner == who && voices[i].active) begin
        best = voices[i].prio;
        w.slot_result = 6'(i);
      end
    return w;
  endfunction

  function automatic alloc_word_t serve_request(input req_t kind, input logic [47:0] d);
    alloc_word_t w;
    w = '{counter_after: 8'h00, owner_touched: FREE_CODE_DEF, slot_result: 6'd0};
    case (kind)
      REQ_WRITE_SLOT: begin
        if (d[4:0] < SLOT_COUNT_DEF)
          voices[d[4:0]] = '{owner: d[12:5], active: d[21], variant: d[20:13],
                             prio: d[37:22]};
      end
      REQ_WRITE_COUNTER: chan_count[d[12:5]] = d[45:38];
      REQ_SELECT:        w = pick_voice(d[12:5], d[20:13]);
      REQ_FIND:          w = find_voice(d[12:5]);
      default: begin
      end
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    alloc_word_t got;
    alloc_word_t want;
    if (rst) begin
      foreach (voices[i])
        voices[i] = '{owner: FREE_CODE_DEF, active: 1'b0, variant: 8'h00, prio: PRIO_NONE};
      foreach (chan_count[i]) chan_count[i] = 8'h00;
      scan_limit = SLOTS_IN_USE_RST;
      pending_allocs.delete();
      errors = 0;
      word_no = 0;
    end else begin
      if (cfg_we) scan_limit = cfg_wdata;
      // compare before queuing this edge's request so a stray word is caught
      if (m_tvalid && m_tready) begin
        got = m_tdata[21:0];
        if (pending_allocs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("svsa check: result word %0d with nothing pending: slot %0d owner %0d cnt %0d",
                     word_no, $signed(got.slot_result), got.owner_touched, got.counter_after);
        end else begin
          want = pending_allocs.pop_front();
          if (got.slot_result !== want.slot_result || got.owner_touched !== want.owner_touched ||
              got.counter_after !== want.counter_after) begin
            errors++;
            if (errors <= 10)
              $display({"svsa check: word %0d expected slot %0d owner %0d cnt %0d,",
                        " got slot %0d owner %0d cnt %0d"}, word_no,
                       $signed(want.slot_result), want.owner_touched, want.counter_after,
                       $signed(got.slot_result), got.owner_touched, got.counter_after);
          end
        end
        word_no++;
      end
      if (s_tvalid && s_tready)
        pending_allocs.push_back(serve_request(req_t'(s_tuser), s_tdata));
    end
    fail_count <= errors;
    outstanding <= pending_allocs.size();
  end

endmodule

FILE: test/sound_voice_slot_allocator_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for sound_voice_slot_allocator_core: request stimulus, scan
// count writes and result back-pressure. Depends on svsa_pkg, the core and
// voice_alloc_checker.
module sound_voice_slot_allocator_core_tb;
  import svsa_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        steady = 1'b0;
  int          fail_count;
  int          outstanding;
  int          scan_span = SLOT_COUNT_DEF;
  int          sent = 0;

  sound_voice_slot_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  voice_alloc_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sound_voice_slot_allocator_core: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 30);
  end

  // valid stays high from one word to the next unless a gap is taken
  task automatic send_req(input req_t kind, input logic [4:0] slot, input logic [7:0] owner,
                          input logic [7:0] variant, input logic active,
                          input logic [15:0] prio, input logic [7:0] count);
    int gap;
    gap = (!steady && $urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {2'b00, count, prio, active, variant, owner, slot};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic wr_slot(input logic [4:0] slot, input logic [7:0] owner,
                         input logic [7:0] variant, input logic active, input logic [15:0] prio);
    send_req(REQ_WRITE_SLOT, slot, owner, variant, active, prio, 8'h00);
  endtask

  task automatic wr_count(input logic [7:0] owner, input logic [7:0] count);
    send_req(REQ_WRITE_COUNTER, 5'd0, owner, 8'h00, 1'b0, 16'h0000, count);
  endtask

  task automatic ask(input req_t kind, input logic [7:0] owner, input logic [7:0] variant);
    send_req(kind, 5'd0, owner, variant, 1'b0, 16'h0000, 8'h00);
  endtask

  // scan count writes only while nothing is in flight
  task automatic set_scan_count(input logic [5:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_span = (value > SLOT_COUNT_DEF) ? SLOT_COUNT_DEF : ((value == 0) ? 1 : value);
  endtask

  function automatic logic [7:0] pick_owner();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(5));
    if (r < 80) return FREE_CODE_DEF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_variant();
    if ($urandom_range(99) < 60) return 8'($urandom_range(1));
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_prio();
    int r;
    r = $urandom_range(99);
    if (r < 20) return PRIO_NONE;
    if (r < 35) return 16'($urandom_range(2));
    return 16'($urandom);
  endfunction

  function automatic logic [4:0] pick_slot();
    if ($urandom_range(99) < 80) return 5'($urandom_range(scan_span - 1));
    return 5'($urandom);
  endfunction

  task automatic send_noise();
    req_t kind;
    int   r;
    r = $urandom_range(99);
    kind = (r < 45) ? REQ_WRITE_SLOT : (r < 60) ? REQ_WRITE_COUNTER :
           (r < 85) ? REQ_SELECT : REQ_FIND;
    send_req(kind, pick_slot(), pick_owner(), pick_variant(), $urandom_range(99) < 80,
             pick_prio(), 8'($urandom));
  endtask

  task automatic send_query();
    req_t kind;
    int   r;
    r = $urandom_range(99);
    kind = (r < 50) ? REQ_SELECT : (r < 80) ? REQ_FIND : REQ_WRITE_COUNTER;
    send_req(kind, pick_slot(), pick_owner(), pick_variant(), 1'b1, pick_prio(),
             8'($urandom));
  endtask

  // mostly full tables so select gets past the free and inactive passes
  task automatic run_mix(input int budget);
    int stop;
    stop = sent + budget;
    while (sent < stop) begin
      if ($urandom_range(9) < 7) begin
        for (int i = 0; i < scan_span; i++)
          send_req(REQ_WRITE_SLOT, 5'(i),
                   ($urandom_range(19) == 0) ? FREE_CODE_DEF : pick_owner() & 8'hFE,
                   pick_variant(), $urandom_range(9) != 0, pick_prio(), 8'h00);
        repeat ($urandom_range(2, 6)) send_query();
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table, full scan
    ask(REQ_FIND, 8'h00, 8'h00);
    ask(REQ_FIND, FREE_CODE_DEF, 8'h00);
    wr_slot(5'd31, 8'h00, 8'hFF, 1'b1, 16'h0000);
    wr_slot(5'd1, FREE_CODE_DEF, 8'h00, 1'b1, 16'h8000);
    ask(REQ_FIND, 8'h00, 8'h00);
    ask(REQ_FIND, FREE_CODE_DEF, 8'h00);         // free owner matched like any other
    ask(REQ_SELECT, 8'h00, 8'hFF);               // free slot, no counter touched
    wr_count(8'd5, 8'h13);
    wr_count(8'd7, 8'h10);
    wr_count(FREE_CODE_DEF, 8'hFF);

    // two slots: walk the inactive, match and lowest priority passes
    set_scan_count(6'd2);
    wr_slot(5'd0, 8'd5, 8'd3, 1'b0, 16'd100);
    wr_slot(5'd1, 8'd7, 8'd9, 1'b1, 16'd50);
    ask(REQ_SELECT, 8'd1, 8'd1);
    wr_slot(5'd0, 8'd5, 8'd3, 1'b1, 16'd100);
    ask(REQ_SELECT, 8'd7, 8'd9);                 // low nibble zero, no decrement
    ask(REQ_SELECT, 8'd1, 8'd1);
    wr_slot(5'd0, 8'd5, 8'd3, 1'b1, 16'd50);
    ask(REQ_SELECT, 8'd1, 8'd1);                 // tie goes to the earlier slot
    wr_slot(5'd1, 8'd5, 8'd4, 1'b1, 16'd50);
    ask(REQ_FIND, 8'd5, 8'd0);                   // tie goes to the later slot
    wr_slot(5'd0, 8'd5, 8'd3, 1'b1, PRIO_NONE);
    wr_slot(5'd1, 8'd5, 8'd4, 1'b1, PRIO_NONE);
    ask(REQ_SELECT, 8'd1, 8'd1);                 // every priority at the ceiling

    set_scan_count(6'd0);
    ask(REQ_SELECT, 8'd5, 8'd3);
    ask(REQ_FIND, 8'd5, 8'd0);
    run_mix(20);

    set_scan_count(6'd4);
    run_mix(80);
    set_scan_count(6'd1);
    run_mix(30);
    set_scan_count(6'd63);
    steady <= 1'b1;
    run_mix(60);
    steady <= 1'b0;
    run_mix(70);
    set_scan_count(6'd7);
    run_mix(60);
    set_scan_count(6'd32);
    run_mix(90);

    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("sound_voice_slot_allocator_core: match");
    else
      $display("sound_voice_slot_allocator_core: mismatch");
    $finish;
  end

endmodule

FILE: sound_voice_slot_allocator_core.f
sv/svsa_pkg.sv
sv/svsa_slot_table.sv
sv/svsa_ctr_table.sv
sv/svsa_scan_unit.sv
sv/sound_voice_slot_allocator_core.sv
sv/svsa_checker.sv
test/voice_alloc_checker.sv
test/sound_voice_slot_allocator_core_tb.sv
